### hw/rtl/slseq_pkg.sv
// slseq_pkg: shared types, character codes and the hex nibble decoder
// for the serial line sequence checker. No dependencies.
`timescale 1ns / 1ps

package slseq_pkg;

	localparam logic [7:0] CHAR_NUL = 8'h00;
	localparam logic [7:0] CHAR_CR  = 8'h0D;
	localparam logic [7:0] CHAR_T   = 8'h74;

	localparam int unsigned LEN_W = 5;
	localparam logic [LEN_W-1:0] LEN_MAX    = 5'd31;
	localparam logic [LEN_W-1:0] LEN_ACCEPT = 5'd21;
	localparam logic [LEN_W-1:0] DATA_FIRST = 5'd5;
	localparam logic [LEN_W-1:0] DATA_LAST  = 5'd20;

	typedef logic [7:0]  char_t;
	typedef logic [63:0] value_t;

	typedef struct packed {
		value_t frame_value;
		value_t expected_value;
		logic   out_of_sequence;
	} result_t;

	// Hex digit to nibble; anything that is not a hex digit gives zero
	function automatic logic [3:0] nibble_of(input char_t ch);
		logic [3:0] nib;
		nib = 4'h0;
		if (ch >= 8'h30 && ch <= 8'h39) begin
			nib = ch[3:0];
		end else if ((ch >= 8'h61 && ch <= 8'h66) || (ch >= 8'h41 && ch <= 8'h46)) begin
			nib = ch[3:0] + 4'd9;
		end
		return nib;
	endfunction

endpackage

### hw/rtl/slseq_char_if.sv
// slseq_char_if: valid/ready channel that carries one received character.
// Depends on slseq_pkg.
`timescale 1ns / 1ps

interface slseq_char_if;
	import slseq_pkg::*;

	logic  valid;
	logic  ready;
	char_t rx_char;

	modport source (output valid, output rx_char, input ready);
	modport sink (input valid, input rx_char, output ready);
endinterface

### hw/rtl/slseq_result_if.sv
// slseq_result_if: valid/ready channel that carries one sequence result.
// Depends on slseq_pkg.
`timescale 1ns / 1ps

interface slseq_result_if;
	import slseq_pkg::*;

	logic   valid;
	logic   ready;
	value_t frame_value;
	value_t expected_value;
	logic   out_of_sequence;

	modport source (output valid, output frame_value, output expected_value,
		output out_of_sequence, input ready);
	modport sink (input valid, input frame_value, input expected_value,
		input out_of_sequence, output ready);
endinterface

### hw/rtl/slseq_line_parser.sv
// slseq_line_parser: input register, line state and frame decode.
// Depends on slseq_pkg and slseq_char_if.
`timescale 1ns / 1ps

module slseq_line_parser (
	input  logic               clk,
	input  logic               arst_n,
	slseq_char_if.sink         rx,
	input  logic               out_free,
	output logic               res_valid,
	output slseq_pkg::result_t res
);
	import slseq_pkg::*;

	logic             valid_s1;
	char_t            char_s1;
	logic [LEN_W-1:0] len_q;
	logic             start_t_q;
	value_t           acc_q;
	value_t           last_q;

	logic             is_cr;
	logic             is_nul;
	logic             accept;
	logic             advance;
	logic [3:0]       k;
	logic [5:0]       shift;
	value_t           acc_d;
	value_t           expected;

	// Decode the registered character against the line state
	always_comb begin
		is_cr    = (char_s1 == CHAR_CR);
		is_nul   = (char_s1 == CHAR_NUL);
		accept   = valid_s1 && is_cr && start_t_q && (len_q == LEN_ACCEPT);
		advance  = valid_s1 && (!accept || out_free);
		expected = last_q + 64'd1;
		k        = 4'(len_q - DATA_FIRST);
		shift    = {k[3:1], ~k[0], 2'b00};
		acc_d    = acc_q;
		acc_d[shift +: 4] = nibble_of(char_s1);
	end

	assign rx.ready  = !valid_s1 || advance;
	assign res_valid = accept;
	assign res.frame_value     = acc_q;
	assign res.expected_value  = expected;
	assign res.out_of_sequence = (acc_q != expected);

	// Hold the incoming character until the line state has taken it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			char_s1 <= rx.rx_char;
		end
	end

	// Advance the line state; drop the line on NUL or CR
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q     <= '0;
			start_t_q <= 1'b0;
			acc_q     <= '0;
			last_q    <= '1;
		end else if (advance) begin
			if (is_nul || is_cr) begin
				len_q     <= '0;
				start_t_q <= 1'b0;
				acc_q     <= '0;
				if (accept) begin
					last_q <= acc_q;
				end
			end else if (len_q < LEN_MAX) begin
				len_q <= len_q + 5'd1;
				if (len_q == '0) begin
					start_t_q <= (char_s1 == CHAR_T);
				end
				if (len_q >= DATA_FIRST && len_q <= DATA_LAST) begin
					acc_q <= acc_d;
				end
			end
		end
	end

endmodule

### hw/rtl/slseq_out_reg.sv
// slseq_out_reg: result register in front of the output channel.
// Depends on slseq_pkg and slseq_result_if.
`timescale 1ns / 1ps

module slseq_out_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               res_valid,
	input  slseq_pkg::result_t res,
	output logic               out_free,
	slseq_result_if.source     tx
);
	import slseq_pkg::*;

	logic    valid_q;
	result_t data_q;

	// Slot is free when empty or when the held request leaves this cycle
	assign out_free = !valid_q || tx.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && res_valid) begin
			data_q <= res;
		end
	end

	assign tx.valid           = valid_q;
	assign tx.frame_value     = data_q.frame_value;
	assign tx.expected_value  = data_q.expected_value;
	assign tx.out_of_sequence = data_q.out_of_sequence;

endmodule

### hw/rtl/slcan_sequence_checker_top.sv
// slcan_sequence_checker_top: serial line sequence checker, top level.
// Depends on slseq_pkg, slseq_char_if, slseq_result_if, slseq_line_parser, slseq_out_reg.
//
//   channel | dir | payload                                          | request
//   rx      | in  | rx_char[7:0]                                     | one character
//   tx      | out | frame_value[63:0] expected_value[63:0] oos[0]   | one accepted line
//
// One character per cycle sustained unless a stalled tx blocks a result. A
// character sits in the input register, then updates the line state; a CR that
// completes a valid line loads the result register. Reset clears the line state
// and sets the last value to all ones. A stalled tx holds rx only when a further
// result would need the result register.
`timescale 1ns / 1ps

module slcan_sequence_checker_top (
	input  logic           clk,
	input  logic           arst_n,
	slseq_char_if.sink     rx,
	slseq_result_if.source tx
);
	import slseq_pkg::*;

	logic    res_valid;
	result_t res;
	logic    out_free;

	slseq_line_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx),
		.out_free  (out_free),
		.res_valid (res_valid),
		.res       (res)
	);

	slseq_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.out_free  (out_free),
		.tx        (tx)
	);

endmodule

### verif/slcan_sequence_checker_top_tb.sv
// slcan_sequence_checker_top_tb: drives received characters into the sequence
// checker and checks every accepted line against a predictor of the line state.
// Depends on slseq_pkg, slseq_char_if, slseq_result_if, slcan_sequence_checker_top.
`timescale 1ns / 1ps

module slcan_sequence_checker_top_tb;
	import slseq_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200_000;
	localparam int unsigned RANDOM_CHARS = 700;

	typedef enum logic {END_CR, END_NUL} line_end_e;
	typedef enum logic [1:0] {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_HOLD} sink_mode_e;

	// One character request, with a fixed expectation on the line terminator
	typedef struct {
		char_t   ch;
		bit      typed;
		result_t typed_result;
	} char_req_t;

	// One directed line; the fixed result is used only where typed is set
	typedef struct {
		string     text;
		line_end_e ending;
		bit        typed;
		value_t    frame;
		value_t    seq_next;
		logic      oos;
	} line_row_t;

	logic clk;
	logic arst_n;

	slseq_char_if   rx_ch ();
	slseq_result_if tx_ch ();

	slcan_sequence_checker_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.tx     (tx_ch)
	);

	char_req_t char_stream [$];
	result_t   pending_results [$];

	// Predicted line state
	logic [LEN_W-1:0] pl_length;
	bit               pl_starts_t;
	value_t           pl_accum;
	value_t           pl_last;

	int unsigned mismatch_count;
	bit          all_sent;
	bit          draining;

	// Sender and receiver pacing
	char_req_t   on_wire;
	int unsigned burst_left;
	int unsigned gap_left;
	sink_mode_e  sink_mode;
	int unsigned sink_left;
	logic        sink_ready;
	result_t     want;

	line_row_t line_table [15] = '{
		'{"t00000000000000000000", END_CR, 1'b1, 64'h0, 64'h0, 1'b0},
		'{"t7FF80100000000000000", END_CR, 1'b1, 64'h1, 64'h1, 1'b0},
		'{"t12380500", END_NUL, 1'b0, 64'h0, 64'h0, 1'b0},
		'{"T12380200000000000000", END_CR, 1'b0, 64'h0, 64'h0, 1'b0},
		'{"t1230200000000000000", END_CR, 1'b0, 64'h0, 64'h0, 1'b0},
		'{"t123880200000000000000", END_CR, 1'b0, 64'h0, 64'h0, 1'b0},
		'{"t12380202020202020202020202020202020202020202", END_CR, 1'b0,
			64'h0, 64'h0, 1'b0},
		'{"", END_CR, 1'b0, 64'h0, 64'h0, 1'b0},
		'{"", END_NUL, 1'b0, 64'h0, 64'h0, 1'b0},
		'{"t12380200000000000000", END_CR, 1'b1, 64'h2, 64'h2, 1'b0},
		'{"t1238ffffffffffffffff", END_CR, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 64'h3, 1'b1},
		'{"t12380000000000000000", END_CR, 1'b1, 64'h0, 64'h0, 1'b0},
		'{"t1238FEDCBA9876543210", END_CR, 1'b1, 64'h1032_5476_98BA_DCFE, 64'h1, 1'b1},
		'{"t\377\200 ~/:@G\140g\377\200/:@G\140gz~", END_CR, 1'b0, 64'h0, 64'h0, 1'b0},
		'{"t12389a8b7c6d5e4f3a2b", END_CR, 1'b0, 64'h0, 64'h0, 1'b0}
	};

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string field, input value_t got, input value_t exp_val);
		mismatch_count++;
		$display("%0t ns: %s: got %h, wanted %h", $time, field, got, exp_val);
	endtask

	function automatic logic [3:0] hex_nibble(input char_t c);
		if (c >= "0" && c <= "9")
			return 4'(c - "0");
		if (c >= "a" && c <= "f")
			return 4'(c - "a" + 10);
		if (c >= "A" && c <= "F")
			return 4'(c - "A" + 10);
		return 4'h0;
	endfunction

	function automatic bit is_hex(input char_t c);
		return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
	endfunction

	// Advance the predicted line state by one accepted character
	function automatic void decode_line_char(input char_req_t req);
		result_t     res;
		int unsigned slot;
		int unsigned shift;
		if (req.ch == CHAR_NUL) begin
			pl_length = '0;
			pl_starts_t = 1'b0;
			pl_accum = '0;
		end else if (req.ch == CHAR_CR) begin
			if (pl_starts_t && pl_length == LEN_ACCEPT) begin
				res.frame_value = pl_accum;
				res.expected_value = pl_last + 64'd1;
				res.out_of_sequence = (pl_accum != pl_last + 64'd1);
				pl_last = pl_accum;
				pending_results.push_back(req.typed ? req.typed_result : res);
			end
			pl_length = '0;
			pl_starts_t = 1'b0;
			pl_accum = '0;
		end else if (pl_length < LEN_MAX) begin
			if (pl_length == '0)
				pl_starts_t = (req.ch == CHAR_T);
			if (pl_length >= DATA_FIRST && pl_length <= DATA_LAST) begin
				// First pair is the low byte; high nibble comes first in a pair
				slot = pl_length - DATA_FIRST;
				shift = (slot / 2) * 8 + ((slot % 2 == 0) ? 4 : 0);
				pl_accum |= value_t'(hex_nibble(req.ch)) << shift;
			end
			pl_length = pl_length + 1'b1;
		end
	endfunction

	function automatic void push_char(input char_t ch);
		char_req_t req;
		req.ch = ch;
		req.typed = 1'b0;
		req.typed_result = '0;
		char_stream.push_back(req);
	endfunction

	// Any character but NUL and CR
	function automatic char_t plain_char();
		char_t c;
		do
			c = char_t'($urandom_range(1, 255));
		while (c == CHAR_CR);
		return c;
	endfunction

	// Queue a line body for a value; returns the value the line really carries
	function automatic value_t push_frame(input char_t start, input value_t v);
		value_t      got;
		char_t       c;
		logic [3:0]  nib;
		int unsigned shift;
		got = v;
		push_char(start);
		repeat (4) push_char(plain_char());
		for (int k = 0; k < 16; k++) begin
			shift = (k / 2) * 8 + ((k % 2 == 0) ? 4 : 0);
			nib = v[shift +: 4];
			if ($urandom_range(0, 19) == 0) begin
				// a stray character reads as zero
				do
					c = plain_char();
				while (is_hex(c));
				got[shift +: 4] = 4'h0;
			end else if (nib < 4'd10) begin
				c = "0" + nib;
			end else begin
				c = ($urandom_range(0, 1) ? "a" : "A") + nib - 8'd10;
			end
			push_char(c);
		end
		return got;
	endfunction

	// Build the stimulus, hold reset, then wait for the results to drain
	initial begin
		char_req_t   req;
		value_t      gen_last;
		value_t      v;
		char_t       c;
		int unsigned random_start;
		int unsigned kind;
		arst_n <= 1'b0;
		mismatch_count = 0;
		all_sent = 1'b0;
		draining = 1'b0;
		pl_length = '0;
		pl_starts_t = 1'b0;
		pl_accum = '0;
		pl_last = '1;

		foreach (line_table[i]) begin
			for (int j = 0; j < line_table[i].text.len(); j++)
				push_char(char_t'(line_table[i].text[j]));
			req.ch = (line_table[i].ending == END_CR) ? CHAR_CR : CHAR_NUL;
			req.typed = line_table[i].typed;
			req.typed_result = '{line_table[i].frame, line_table[i].seq_next,
				line_table[i].oos};
			char_stream.push_back(req);
		end

		// Mostly well-formed lines, some broken ones, some raw noise
		gen_last = 64'h2b3a_4f5e_6d7c_8b9a;
		random_start = char_stream.size();
		while (char_stream.size() - random_start < RANDOM_CHARS) begin
			case ($urandom_range(0, 9))
				0: v = gen_last;
				1: v = gen_last + 64'd2;
				2: v = {$urandom, $urandom};
				3: v = '1;
				default: v = gen_last + 64'd1;
			endcase
			kind = $urandom_range(0, 99);
			if (kind < 70) begin
				gen_last = push_frame(CHAR_T, v);
				push_char(CHAR_CR);
			end else if (kind < 74) begin
				void'(push_frame(CHAR_T, v));
				push_char(CHAR_NUL);
			end else if (kind < 78) begin
				void'(push_frame(CHAR_T, v));
				repeat ($urandom_range(1, 12)) push_char(plain_char());
				push_char(CHAR_CR);
			end else if (kind < 82) begin
				do
					c = plain_char();
				while (c == CHAR_T);
				void'(push_frame(c, v));
				push_char(CHAR_CR);
			end else if (kind < 86) begin
				push_char(CHAR_T);
				repeat ($urandom_range(0, 19)) push_char(plain_char());
				push_char(CHAR_CR);
			end else begin
				repeat ($urandom_range(0, 40)) push_char(char_t'($urandom_range(0, 255)));
				push_char(CHAR_CR);
			end
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (!all_sent) @(posedge clk);
		draining = 1'b1;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("slcan_sequence_checker_top_tb: clean");
		else
			$display("slcan_sequence_checker_top_tb: errors");
		$finish;
	end

	// Sender: bursts of requests with random gaps; hold a request until taken
	initial begin
		rx_ch.valid <= 1'b0;
		rx_ch.rx_char <= '0;
		burst_left = $urandom_range(1, 40);
		gap_left = 0;
		while (arst_n !== 1'b1) @(posedge clk);
		forever begin
			@(posedge clk);
			if (rx_ch.valid && rx_ch.ready) begin
				decode_line_char(on_wire);
				if (char_stream.size() == 0)
					all_sent = 1'b1;
			end
			if (!(rx_ch.valid && !rx_ch.ready)) begin
				if (gap_left > 0 || char_stream.size() == 0) begin
					if (gap_left > 0)
						gap_left--;
					rx_ch.valid <= 1'b0;
				end else begin
					on_wire = char_stream.pop_front();
					rx_ch.valid <= 1'b1;
					rx_ch.rx_char <= on_wire.ch;
					burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 40);
						case ($urandom_range(0, 9))
							0, 1, 2, 3: gap_left = 0;
							4, 5, 6, 7: gap_left = $urandom_range(1, 4);
							8: gap_left = $urandom_range(5, 12);
							default: gap_left = $urandom_range(20, 40);
						endcase
					end
				end
			end
		end
	end

	// Receiver: check each result, then stall on a pattern that changes now and then
	initial begin
		tx_ch.ready <= 1'b0;
		sink_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && tx_ch.valid && tx_ch.ready) begin
				if (pending_results.size() == 0) begin
					report_mismatch("result with no request pending", tx_ch.frame_value, '0);
				end else begin
					want = pending_results.pop_front();
					if (tx_ch.frame_value !== want.frame_value)
						report_mismatch("frame_value", tx_ch.frame_value, want.frame_value);
					if (tx_ch.expected_value !== want.expected_value)
						report_mismatch("expected_value", tx_ch.expected_value,
							want.expected_value);
					if (tx_ch.out_of_sequence !== want.out_of_sequence)
						report_mismatch("out_of_sequence", value_t'(tx_ch.out_of_sequence),
							value_t'(want.out_of_sequence));
				end
			end
			if (sink_left == 0) begin
				sink_mode = sink_mode_e'($urandom_range(0, 3));
				sink_left = $urandom_range(16, 96);
			end
			sink_left--;
			case (sink_mode)
				SINK_OPEN:   sink_ready = 1'b1;
				SINK_COIN:   sink_ready = 1'($urandom_range(0, 1));
				SINK_SPARSE: sink_ready = ($urandom_range(0, 3) == 0);
				default:     sink_ready = (sink_left % 20 == 0);
			endcase
			tx_ch.ready <= draining || sink_ready;
		end
	end

	// Timeout
	initial begin
		int unsigned cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("slcan_sequence_checker_top_tb: errors");
		$finish;
	end

endmodule
